// ===== src/gbns_pkg.sv =====
// ----------------------------------------------------------------------------
// gbns_pkg: shared types, constants and bit search helpers
// Field widths, request codes, controller states and the command/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package gbns_pkg;

    localparam int MAX_DIM_DEF = 1024;   // default cells per axis
    localparam int WORD_BITS   = 64;     // bits per map word
    localparam int BIT_W       = 6;      // log2 of WORD_BITS
    localparam int COORD_W     = 11;     // signed cell coordinate
    localparam int CFG_W       = 11;     // grid size registers
    localparam int CFG_IDX_W   = 2;      // configuration register index
    localparam int HIT_W       = 12;     // signed scan result

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        FUNC_SET   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_PROBE = 2'd2,
        FUNC_SCAN  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EVAL,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic clr_step;   // zero one word of each map
        logic load;       // capture the request
        logic lookup;     // issue the first reads, resolve out-of-bounds
        logic eval;       // act on the word just read
        logic first;      // word under evaluation is the start word
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;   // clearing pass is at its final word
        logic oob;        // captured cell lies outside the grid
        logic done;       // request finishes on this evaluation
    } ctrl_stat_t;

    // lowest set bit; zero for an empty word
    function automatic logic [BIT_W-1:0] low_set(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] n;
        n = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                n = BIT_W'(i);
            end
        end
        return n;
    endfunction

    // highest set bit; zero for an empty word
    function automatic logic [BIT_W-1:0] high_set(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (w[i])
            begin
                n = BIT_W'(i);
            end
        end
        return n;
    endfunction

endpackage

// ===== src/gbns_ram.sv =====
// ----------------------------------------------------------------------------
// gbns_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gbns_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/gbns_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbns_ctrl: request sequencer
// Runs the clearing pass after reset, then steps each request through
// capture, first lookup and one evaluation per map word.
// ----------------------------------------------------------------------------
module gbns_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output gbns_pkg::ctrl_cmd_t   cmd,
    input  gbns_pkg::ctrl_stat_t  stat
);

    gbns_pkg::state_t state_reg;
    gbns_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbns_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            gbns_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = gbns_pkg::ST_IDLE;
                end
            end
            gbns_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = gbns_pkg::ST_LOOKUP;
                end
            end
            gbns_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = stat.oob ? gbns_pkg::ST_IDLE : gbns_pkg::ST_EVAL;
            end
            gbns_pkg::ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                cmd.first  = 1'b1;
                state_next = stat.done ? gbns_pkg::ST_IDLE : gbns_pkg::ST_SCAN;
            end
            gbns_pkg::ST_SCAN:
            begin
                cmd.eval = 1'b1;
                if (stat.done)
                begin
                    state_next = gbns_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbns_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/gbns_datapath.sv =====
// ----------------------------------------------------------------------------
// gbns_datapath: grid maps, request registers and word evaluation
// Holds both bit maps, the grid size registers, the word walk pointer and
// the result registers.
// ----------------------------------------------------------------------------
module gbns_datapath #(
    parameter int MAX_DIM = gbns_pkg::MAX_DIM_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [gbns_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gbns_pkg::CFG_W-1:0]             cfg_wr_data,
    input  logic [1:0]                             func,
    input  logic signed [gbns_pkg::COORD_W-1:0]    cell_x,
    input  logic signed [gbns_pkg::COORD_W-1:0]    cell_y,
    input  logic                                   along_x,
    input  logic                                   toward_plus,
    input  logic                                   seek_open,
    input  gbns_pkg::ctrl_cmd_t                    cmd,
    output gbns_pkg::ctrl_stat_t                   stat,
    output logic                                   done,
    output logic                                   cell_blocked,
    output logic                                   out_of_bounds,
    output logic signed [gbns_pkg::HIT_W-1:0]      hit_coord
);

    localparam int WB      = gbns_pkg::WORD_BITS;
    localparam int BW      = gbns_pkg::BIT_W;
    localparam int CW      = gbns_pkg::COORD_W;
    localparam int WPL     = MAX_DIM / WB;
    localparam int DEPTH   = MAX_DIM * WPL;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int WC_W    = $clog2(WPL) + 2;
    localparam int HW      = (WC_W + 7 > 13) ? WC_W + 7 : 13;
    localparam int DIM_RST = (MAX_DIM < 1024) ? MAX_DIM : 1024;

    // configuration
    logic [gbns_pkg::CFG_W-1:0] width_reg;
    logic [gbns_pkg::CFG_W-1:0] height_reg;
    logic [gbns_pkg::CFG_W-1:0] cfg_sat;

    // request
    gbns_pkg::func_t        func_reg;
    logic signed [CW-1:0]   cx_reg;
    logic signed [CW-1:0]   cy_reg;
    logic                   along_x_reg;
    logic                   toward_plus_reg;
    logic                   seek_open_reg;
    logic [CW-1:0]          x_u;
    logic [CW-1:0]          y_u;

    // word walk
    logic signed [WC_W-1:0] idx_reg;
    logic signed [WC_W-1:0] idx_next;
    logic signed [WC_W-1:0] x_word;
    logic signed [WC_W-1:0] y_word;
    logic signed [WC_W-1:0] row_rd_word;
    logic signed [WC_W-1:0] col_rd_word;
    logic [ADDR_W-1:0]      row_base;
    logic [ADDR_W-1:0]      col_base;
    logic [ADDR_W-1:0]      row_addr;
    logic [ADDR_W-1:0]      col_addr;
    logic [ADDR_W-1:0]      row_rd_addr;
    logic [ADDR_W-1:0]      col_rd_addr;
    logic [ADDR_W-1:0]      clr_cnt_reg;

    // memories
    logic                   map_wr_en;
    logic [ADDR_W-1:0]      row_wr_addr;
    logic [ADDR_W-1:0]      col_wr_addr;
    logic [WB-1:0]          row_wr_data;
    logic [WB-1:0]          col_wr_data;
    logic [WB-1:0]          row_rd_data;
    logic [WB-1:0]          col_rd_data;
    logic [WB-1:0]          row_bit;
    logic [WB-1:0]          col_bit;

    // evaluation
    logic                   oob;
    logic [BW-1:0]          sh;
    logic [WB-1:0]          scan_w;
    logic [WB-1:0]          first_mask;
    logic [WB-1:0]          masked;
    logic                   found;
    logic [BW-1:0]          lo_pos;
    logic [BW-1:0]          hi_pos;
    logic signed [HW-1:0]   base_s;
    logic signed [HW-1:0]   nxt_base_s;
    logic signed [HW-1:0]   lim_s;
    logic signed [HW-1:0]   fwd_hit;
    logic signed [HW-1:0]   bwd_hit;
    logic signed [HW-1:0]   scan_hit;
    logic                   fwd_end;
    logic                   bwd_end;
    logic                   scan_done;
    logic signed [HW-1:0]   miss_hit;
    logic                   res_load;

    // result
    logic                   done_reg;
    logic                   blocked_reg;
    logic                   oob_reg;
    logic signed [gbns_pkg::HIT_W-1:0] hit_reg;

    // ---- configuration registers -------------------------------------------
    assign cfg_sat = ({2'b00, cfg_wr_data} > 13'(MAX_DIM))
                   ? gbns_pkg::CFG_W'(MAX_DIM) : cfg_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gbns_pkg::CFG_W'(DIM_RST);
            height_reg <= gbns_pkg::CFG_W'(DIM_RST);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                gbns_pkg::CFG_GRID_WIDTH:  width_reg  <= cfg_sat;
                gbns_pkg::CFG_GRID_HEIGHT: height_reg <= cfg_sat;
                default:
                begin
                end
            endcase
        end
    end

    // ---- request capture ---------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg        <= gbns_pkg::func_t'(func);
            cx_reg          <= cell_x;
            cy_reg          <= cell_y;
            along_x_reg     <= along_x;
            toward_plus_reg <= toward_plus;
            seek_open_reg   <= seek_open;
        end
    end

    assign x_u = cx_reg;
    assign y_u = cy_reg;
    assign oob = cx_reg[CW-1] | cy_reg[CW-1] | (x_u >= width_reg) | (y_u >= height_reg);

    // ---- addressing --------------------------------------------------------
    assign row_base = ADDR_W'(y_u * WPL);
    assign col_base = ADDR_W'(x_u * WPL);
    assign x_word   = WC_W'(x_u >> BW);
    assign y_word   = WC_W'(y_u >> BW);
    assign row_addr = ADDR_W'(row_base + ADDR_W'(x_word));
    assign col_addr = ADDR_W'(col_base + ADDR_W'(y_word));

    assign idx_next    = toward_plus_reg ? idx_reg + WC_W'(1) : idx_reg - WC_W'(1);
    assign row_rd_word = cmd.lookup ? x_word : idx_next;
    assign col_rd_word = cmd.lookup ? y_word : idx_next;
    assign row_rd_addr = ADDR_W'(row_base + ADDR_W'(row_rd_word));
    assign col_rd_addr = ADDR_W'(col_base + ADDR_W'(col_rd_word));

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            idx_reg <= along_x_reg ? x_word : y_word;
        end
        else if (cmd.eval)
        begin
            idx_reg <= idx_next;
        end
    end

    // ---- clearing pass -----------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
        end
    end

    // ---- map writes: clear sweep or read-modify-write of one cell ----------
    assign row_bit   = {{(WB-1){1'b0}}, 1'b1} << x_u[BW-1:0];
    assign col_bit   = {{(WB-1){1'b0}}, 1'b1} << y_u[BW-1:0];
    assign map_wr_en = cmd.clr_step
                     | (cmd.eval & ((func_reg == gbns_pkg::FUNC_SET)
                                  | (func_reg == gbns_pkg::FUNC_CLEAR)));
    assign row_wr_addr = cmd.clr_step ? clr_cnt_reg : row_addr;
    assign col_wr_addr = cmd.clr_step ? clr_cnt_reg : col_addr;

    always_comb
    begin
        if (cmd.clr_step)
        begin
            row_wr_data = '0;
            col_wr_data = '0;
        end
        else if (func_reg == gbns_pkg::FUNC_SET)
        begin
            row_wr_data = row_rd_data | row_bit;
            col_wr_data = col_rd_data | col_bit;
        end
        else
        begin
            row_wr_data = row_rd_data & ~row_bit;
            col_wr_data = col_rd_data & ~col_bit;
        end
    end

    gbns_ram #(
        .WIDTH (WB),
        .DEPTH (DEPTH)
    ) u_row_map (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (row_wr_addr),
        .wr_data (row_wr_data),
        .rd_addr (row_rd_addr),
        .rd_data (row_rd_data)
    );

    gbns_ram #(
        .WIDTH (WB),
        .DEPTH (DEPTH)
    ) u_col_map (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (col_wr_addr),
        .wr_data (col_wr_data),
        .rd_addr (col_rd_addr),
        .rd_data (col_rd_data)
    );

    // ---- scan word evaluation ----------------------------------------------
    assign sh         = along_x_reg ? x_u[BW-1:0] : y_u[BW-1:0];
    assign scan_w     = (along_x_reg ? row_rd_data : col_rd_data)
                      ^ {WB{seek_open_reg}};
    assign first_mask = toward_plus_reg ? ({WB{1'b1}} << sh)
                                        : ({WB{1'b1}} >> (BW'(WB - 1) - sh));
    assign masked     = cmd.first ? (scan_w & first_mask) : scan_w;
    assign found      = |masked;
    assign lo_pos     = gbns_pkg::low_set(masked);
    assign hi_pos     = gbns_pkg::high_set(masked);

    assign base_s     = HW'(idx_reg) <<< BW;
    assign nxt_base_s = HW'(idx_next) <<< BW;
    assign lim_s      = $signed(HW'(along_x_reg ? width_reg : height_reg));
    assign fwd_hit    = base_s + $signed(HW'(lo_pos));
    assign bwd_hit    = base_s + $signed(HW'(hi_pos));
    assign miss_hit   = toward_plus_reg ? lim_s : -HW'(1);

    // forward walk stops past the last word or once a word base reaches the limit
    assign fwd_end   = (idx_next >= $signed(WC_W'(WPL))) | (nxt_base_s >= lim_s);
    assign bwd_end   = (idx_reg == '0);
    assign scan_done = found | (toward_plus_reg ? fwd_end : bwd_end);

    always_comb
    begin
        if (!found)
        begin
            scan_hit = miss_hit;
        end
        else if (!toward_plus_reg)
        begin
            scan_hit = bwd_hit;
        end
        else
        begin
            // clamp hits on bits left past the edge of the grid
            scan_hit = (fwd_hit >= lim_s) ? lim_s : fwd_hit;
        end
    end

    assign stat.clr_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign stat.oob      = oob;
    assign stat.done     = (func_reg != gbns_pkg::FUNC_SCAN) | scan_done;

    // ---- result registers --------------------------------------------------
    assign res_load = (cmd.lookup & oob) | (cmd.eval & stat.done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup && oob)
        begin
            blocked_reg <= 1'b0;
            oob_reg     <= 1'b1;
            hit_reg     <= (func_reg == gbns_pkg::FUNC_SCAN)
                         ? gbns_pkg::HIT_W'(miss_hit) : '0;
        end
        else if (cmd.eval && stat.done)
        begin
            blocked_reg <= (func_reg == gbns_pkg::FUNC_PROBE) & row_rd_data[x_u[BW-1:0]];
            oob_reg     <= 1'b0;
            hit_reg     <= (func_reg == gbns_pkg::FUNC_SCAN)
                         ? gbns_pkg::HIT_W'(scan_hit) : '0;
        end
    end

    assign done          = done_reg;
    assign cell_blocked  = blocked_reg;
    assign out_of_bounds = oob_reg;
    assign hit_coord     = hit_reg;

endmodule

// ===== src/grid_bitmap_nearest_scan_core.sv =====
// ----------------------------------------------------------------------------
// grid_bitmap_nearest_scan_core: collision grid with nearest-cell scan
// Row-major and column-major bit maps of a grid with set, clear, probe and
// word-at-a-time nearest blocked/open scans along a row or column.
// ----------------------------------------------------------------------------
// Using the block: after reset both maps are zeroed by a clearing pass over
// MAX_DIM*MAX_DIM/64 words (16384 at the default size), one word of each
// map per cycle; busy stays high throughout and grid size writes are taken
// meanwhile. A request transfers when start is high and busy is low. An
// out-of-bounds request ends with its lookup, a set, clear or probe with
// the lookup and one word evaluation, and a scan with the lookup and n word
// evaluations, n being the number of 64-bit words walked (1 to MAX_DIM/64,
// so at most 16 at the default size): each map RAM delivers one word per
// cycle and the walk evaluates it as it arrives. The result shows on
// cell_blocked, out_of_bounds and hit_coord for exactly the one cycle that
// done is high, the cycle in which busy drops; the receiver cannot stall it,
// so capture it then. A new request may transfer in that same cycle. Write
// grid_width (index 0) and grid_height (index 1) only while busy is low;
// values above MAX_DIM saturate and other indexes are dropped.
// ----------------------------------------------------------------------------
module grid_bitmap_nearest_scan_core #(
    parameter int MAX_DIM = gbns_pkg::MAX_DIM_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [gbns_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gbns_pkg::CFG_W-1:0]           cfg_wr_data,
    // request
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           func,
    input  logic signed [gbns_pkg::COORD_W-1:0]  cell_x,
    input  logic signed [gbns_pkg::COORD_W-1:0]  cell_y,
    input  logic                                 along_x,
    input  logic                                 toward_plus,
    input  logic                                 seek_open,
    // result
    output logic                                 done,
    output logic                                 cell_blocked,
    output logic                                 out_of_bounds,
    output logic signed [gbns_pkg::HIT_W-1:0]    hit_coord
);

    gbns_pkg::ctrl_cmd_t  cmd;
    gbns_pkg::ctrl_stat_t stat;

    // sequencer: clearing pass, then capture, lookup and word-by-word walk
    gbns_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // maps, size registers, walk pointer and result registers
    gbns_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .func          (func),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .along_x       (along_x),
        .toward_plus   (toward_plus),
        .seek_open     (seek_open),
        .cmd           (cmd),
        .stat          (stat),
        .done          (done),
        .cell_blocked  (cell_blocked),
        .out_of_bounds (out_of_bounds),
        .hit_coord     (hit_coord)
    );

    // an accepted request occupies the block in the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request transfer did not raise busy");

    // each result is a single-cycle strobe
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // a blocked probe is in bounds and carries no scan coordinate
    a_probe_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && cell_blocked |-> !out_of_bounds && hit_coord == '0)
        else $error("blocked probe result inconsistent");

    // a result strobe always follows a lookup or a word evaluation
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.lookup) || $past(cmd.eval))
        else $error("result strobe without a finishing step");

endmodule
